@@ hdl/ccrp_pkg.sv @@
`default_nettype none
package ccrp_pkg;

  // Base of the program area; offset 0 is the control byte
  localparam logic [15:0] BASE_ADDR      = 16'h8000;
  localparam int          NUM_SLOTS      = 3;
  localparam int          NUM_CODE_BYTES = 12;
  localparam int          BYTES_PER_SLOT = 4;

  // Control byte layout
  localparam int CTRL_LATCH_BIT = 0;
  localparam int CTRL_CMP_LSB   = 1;
  localparam int CTRL_DIS_LSB   = 4;

  // Bus access kind, carried in tuser
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  cmp;
    logic [7:0]  rep;
  } slot_t;

  typedef slot_t [NUM_SLOTS-1:0] slot_arr_t;

  // Code state handed from the set-up registers to the match logic
  typedef struct packed {
    logic      patch_mode;
    logic      patch_mode_next;
    logic [7:0] ctrl;
    slot_arr_t slots;
  } cfg_t;

endpackage
`default_nettype wire

@@ hdl/ccrp_setup.sv @@
`default_nettype none
module ccrp_setup (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire logic [15:0]     addr,
  input  wire logic [7:0]      wdata,
  output ccrp_pkg::cfg_t       cfg
);

  logic [7:0]          code_bytes [ccrp_pkg::NUM_CODE_BYTES];
  logic [7:0]          ctrl;
  ccrp_pkg::slot_arr_t slots;
  logic                patch_mode;
  logic                patch_mode_next;
  logic                latch;
  logic                code_we;
  logic [3:0]          code_idx;

  // Write decode: only set-up mode writes inside the program area count
  always_comb begin
    patch_mode_next = patch_mode;
    latch           = 1'b0;
    code_we         = 1'b0;
    code_idx        = addr[3:0] - 4'd1;
    if (wr_en && !patch_mode && addr[15]) begin
      if (addr[14:0] == 15'd0) begin
        if (wdata[ccrp_pkg::CTRL_LATCH_BIT]) begin
          latch = 1'b1;
        end else begin
          patch_mode_next = 1'b1;
        end
      end else if (addr[14:4] == 11'd0 &&
                   addr[3:0] <= 4'(ccrp_pkg::NUM_CODE_BYTES)) begin
        code_we = 1'b1;
      end
    end
  end

  // Code bytes, control byte, slots and mode
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ccrp_pkg::NUM_CODE_BYTES; i++) begin
        code_bytes[i] <= 8'd0;
      end
      ctrl       <= 8'd0;
      slots      <= '0;
      patch_mode <= 1'b0;
    end else begin
      patch_mode <= patch_mode_next;
      if (code_we) begin
        code_bytes[code_idx] <= wdata;
      end
      if (latch) begin
        ctrl <= wdata;
        for (int k = 0; k < ccrp_pkg::NUM_SLOTS; k++) begin
          slots[k].addr <= ccrp_pkg::BASE_ADDR |
                           {code_bytes[ccrp_pkg::BYTES_PER_SLOT*k],
                            code_bytes[ccrp_pkg::BYTES_PER_SLOT*k + 1]};
          slots[k].cmp  <= code_bytes[ccrp_pkg::BYTES_PER_SLOT*k + 2];
          slots[k].rep  <= code_bytes[ccrp_pkg::BYTES_PER_SLOT*k + 3];
        end
      end
    end
  end

  assign cfg.patch_mode      = patch_mode;
  assign cfg.patch_mode_next = patch_mode_next;
  assign cfg.ctrl            = ctrl;
  assign cfg.slots           = slots;

endmodule
`default_nettype wire

@@ hdl/ccrp_match.sv @@
`default_nettype none
module ccrp_match (
  input  wire ccrp_pkg::cfg_t  cfg,
  input  wire logic            is_read,
  input  wire logic [15:0]     addr,
  input  wire logic [7:0]      cart_data,
  output logic [7:0]           read_data,
  output logic [1:0]           hit_slot
);

  logic found;

  // First enabled slot with a matching address decides the read
  always_comb begin
    found     = 1'b0;
    read_data = is_read ? cart_data : 8'd0;
    hit_slot  = 2'd0;
    if (is_read && cfg.patch_mode) begin
      for (int k = 0; k < ccrp_pkg::NUM_SLOTS; k++) begin
        if (!found && addr == cfg.slots[k].addr &&
            !cfg.ctrl[ccrp_pkg::CTRL_DIS_LSB + k]) begin
          found = 1'b1;
          if (!cfg.ctrl[ccrp_pkg::CTRL_CMP_LSB + k] || cfg.slots[k].cmp == cart_data) begin
            read_data = cfg.slots[k].rep;
            hit_slot  = 2'(k + 1);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/cheat_code_read_patcher.sv @@
// Cheat-code read patcher for the CPU program-space bus.
//
// Input stream (s_*): one request per bus access. s_tuser is the access kind
// (0 read, 1 write); s_tdata carries address, write byte and cartridge byte.
// Output stream (m_*): one result per request, in order: the byte to return
// (0 for writes), the mode after the access and the slot that hit.
//
// After reset the block is in set-up mode with all code state zero. Writes
// to base+1..base+12 store code bytes, a write to base with bit 0 set latches
// the control byte and three slots, and one with bit 0 clear enters patch
// mode until the next reset.
//
// A request accepted into the input register is evaluated there and its result
// is registered in the result register, which drives m_tvalid. The block takes
// one request per cycle while the output is not stalled; the slot address and
// data compares and the write decode are the only logic between the registers.
// When m_tready is low the result holds and one more request can be taken
// into the input register; s_tready then drops until the result leaves.
`default_nettype none
module cheat_code_read_patcher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // bus_address[15:0], write_data[23:16], cart_data[31:24]
  input  wire logic        s_tuser,  // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata   // read_data[7:0], patch_mode[8], hit_slot[10:9], zero
);

  logic              in_valid;
  ccrp_pkg::op_t     in_op;
  logic [15:0]       in_addr;
  logic [7:0]        in_wdata;
  logic [7:0]        in_cdata;
  logic              out_valid;
  logic [7:0]        out_rdata;
  logic              out_mode;
  logic [1:0]        out_hit;
  logic              advance;
  logic              is_read;
  ccrp_pkg::cfg_t    cfg;
  logic [7:0]        rdata;
  logic [1:0]        hit;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign is_read  = (in_op == ccrp_pkg::OP_READ);

  ccrp_setup u_setup (
    .clk   (clk),
    .rst   (rst),
    .wr_en (advance && in_op == ccrp_pkg::OP_WRITE),
    .addr  (in_addr),
    .wdata (in_wdata),
    .cfg   (cfg)
  );

  ccrp_match u_match (
    .cfg       (cfg),
    .is_read   (is_read),
    .addr      (in_addr),
    .cart_data (in_cdata),
    .read_data (rdata),
    .hit_slot  (hit)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_op    <= ccrp_pkg::op_t'(s_tuser);
      in_addr  <= s_tdata[15:0];
      in_wdata <= s_tdata[23:16];
      in_cdata <= s_tdata[31:24];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_rdata <= rdata;
      out_mode  <= cfg.patch_mode_next;
      out_hit   <= hit;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_hit, out_mode, out_rdata};

  // A slot hit only happens in patch mode
  a_hit_needs_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10:9] != 2'd0 |-> m_tdata[8])
    else $error("hit reported outside patch mode");

  // Patch mode is sticky until reset
  a_mode_sticky: assert property (@(posedge clk) disable iff (rst)
    cfg.patch_mode |=> cfg.patch_mode)
    else $error("patch mode dropped without reset");

  // Writes return zero and no hit
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    advance && in_op == ccrp_pkg::OP_WRITE |=> out_rdata == 8'd0 && out_hit == 2'd0)
    else $error("write produced read data");

  // Reported mode never runs ahead of the stored mode
  a_mode_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> cfg.patch_mode)
    else $error("result mode disagrees with stored mode");

endmodule
`default_nettype wire

@@ verif/tb_cheat_code_read_patcher.sv @@
`timescale 1ns / 1ps
module tb_cheat_code_read_patcher;
  import ccrp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    op_t         op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  cdata;
    int unsigned gap;
  } bus_access_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       patch;
    logic [1:0] hit;
  } patch_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // bus_address[15:0], write_data[23:16], cart_data[31:24]
  logic        s_tuser = 1'b0;  // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;  // read_data[7:0], patch_mode[8], hit_slot[10:9], zero

  cheat_code_read_patcher i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Predictor state
  logic [7:0] code_mem [NUM_CODE_BYTES];
  logic [7:0] ctrl_q;
  slot_t      slot_q [NUM_SLOTS];
  logic       patch_on;

  bus_access_t   access_q [$];
  patch_result_t expected_q [$];
  int            err_count = 0;
  int            cycle_count = 0;

  // Apply one bus access to the predicted state and return the expected result
  function automatic patch_result_t patch_bus_access(op_t op, logic [15:0] addr,
                                                     logic [7:0] wdata, logic [7:0] cdata);
    patch_result_t res;
    logic [15:0]   offs;
    bit            decided;
    res = '0;
    decided = 1'b0;
    if (op == OP_WRITE) begin
      // writes only count in set-up mode and inside the program area
      if (!patch_on && addr >= BASE_ADDR) begin
        offs = addr - BASE_ADDR;
        if (offs == 16'd0) begin
          if (wdata[CTRL_LATCH_BIT]) begin
            ctrl_q = wdata;
            for (int k = 0; k < NUM_SLOTS; k++) begin
              slot_q[k].addr = BASE_ADDR | {code_mem[BYTES_PER_SLOT*k],
                                            code_mem[BYTES_PER_SLOT*k+1]};
              slot_q[k].cmp  = code_mem[BYTES_PER_SLOT*k+2];
              slot_q[k].rep  = code_mem[BYTES_PER_SLOT*k+3];
            end
          end else begin
            patch_on = 1'b1;
          end
        end else if (offs <= NUM_CODE_BYTES) begin
          code_mem[offs-1] = wdata;
        end
      end
    end else begin
      res.rdata = cdata;
      if (patch_on) begin
        // first enabled slot on the address decides, hit or not
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (!decided && addr == slot_q[k].addr && !ctrl_q[CTRL_DIS_LSB+k]) begin
            decided = 1'b1;
            if (!ctrl_q[CTRL_CMP_LSB+k] || slot_q[k].cmp == cdata) begin
              res.rdata = slot_q[k].rep;
              res.hit   = 2'(k + 1);
            end
          end
        end
      end
    end
    res.patch = patch_on;
    return res;
  endfunction

  // Stimulus building: sender gap mode is redrawn every 40 requests
  int unsigned built_count = 0;
  bit          gap_mode = 1'b0;

  task automatic add_access(op_t op, logic [15:0] addr, logic [7:0] wdata, logic [7:0] cdata);
    bus_access_t acc;
    if (built_count % 40 == 0) gap_mode = $urandom_range(0, 1);
    acc.op    = op;
    acc.addr  = addr;
    acc.wdata = wdata;
    acc.cdata = cdata;
    acc.gap   = gap_mode ? $urandom_range(0, 16) : 0;
    access_q.push_back(acc);
    built_count++;
  endtask

  function automatic logic [15:0] rand_addr();
    logic [15:0] a;
    a = 16'($urandom_range(0, 65535));
    // mostly program space, sometimes below it
    a[15] = ($urandom_range(0, 19) != 0);
    return a;
  endfunction

  // Driver
  bus_access_t drv_cur;
  bit          have_item = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_q.push_back(patch_bus_access(op_t'(s_tuser), s_tdata[15:0],
                                              s_tdata[23:16], s_tdata[31:24]));
      if (!s_tvalid || s_tready) begin
        if (!have_item && access_q.size() > 0) begin
          drv_cur   = access_q.pop_front();
          have_item = 1'b1;
          gap_left  = drv_cur.gap;
        end
        if (have_item && gap_left == 0) begin
          s_tvalid  <= 1'b1;
          s_tuser   <= drv_cur.op;
          s_tdata   <= {drv_cur.cdata, drv_cur.wdata, drv_cur.addr};
          have_item = 1'b0;
        end else begin
          if (have_item) gap_left--;
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stalls
  int unsigned   results_seen = 0;
  int unsigned   stall_left = 0;
  bit            stall_mode = 1'b0;
  patch_result_t exp_res;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: m_tdata %0h", m_tdata);
          err_count++;
        end else begin
          exp_res = expected_q.pop_front();
          if (m_tdata[7:0] !== exp_res.rdata) begin
            $error("read_data: expected %0h, got %0h", exp_res.rdata, m_tdata[7:0]);
            err_count++;
          end
          if (m_tdata[8] !== exp_res.patch) begin
            $error("patch_mode: expected %0h, got %0h", exp_res.patch, m_tdata[8]);
            err_count++;
          end
          if (m_tdata[10:9] !== exp_res.hit) begin
            $error("hit_slot: expected %0h, got %0h", exp_res.hit, m_tdata[10:9]);
            err_count++;
          end
        end
        results_seen++;
        if (results_seen % 50 == 0) stall_mode = $urandom_range(0, 1);
        stall_left = stall_mode ? $urandom_range(0, 16) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_cheat_code_read_patcher: errors");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [15:0] aim_addr [NUM_SLOTS];
    logic [7:0]  aim_cmp [NUM_SLOTS];
    logic [7:0]  ctrl_val;
    logic [15:0] a;
    logic [7:0]  w;
    int          pick;
    int          k;

    for (int i = 0; i < NUM_CODE_BYTES; i++) code_mem[i] = '0;
    for (int i = 0; i < NUM_SLOTS; i++) slot_q[i] = '0;
    ctrl_q   = '0;
    patch_on = 1'b0;

    // Directed set-up: pass-through reads, ignored writes, a full program and latch
    add_access(OP_READ, 16'hFFFF, 8'h00, 8'hFF);
    add_access(OP_READ, 16'h0000, 8'hFF, 8'h00);
    add_access(OP_WRITE, 16'h0000, 8'hFE, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd13, 8'h5A, 8'hFF);
    add_access(OP_WRITE, 16'hFFFF, 8'h00, 8'h00);
    // slot 1 at FFFF compare AA, slot 2 at 8123 (disabled), slot 3 at 8123
    add_access(OP_WRITE, BASE_ADDR + 16'd1, 8'hFF, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd2, 8'hFF, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd3, 8'hAA, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd4, 8'h55, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd5, 8'h01, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd6, 8'h23, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd7, 8'h00, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd8, 8'h11, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd9, 8'h81, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd10, 8'h23, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd11, 8'h00, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd12, 8'h99, 8'h00);
    add_access(OP_WRITE, BASE_ADDR, 8'h23, 8'h00);
    add_access(OP_READ, 16'hFFFF, 8'h00, 8'hAA);

    // Random set-up traffic; an offset-0 write always keeps bit 0 set here
    for (int i = 0; i < 400; i++) begin
      pick = $urandom_range(0, 99);
      a = rand_addr();
      w = 8'($urandom);
      if (pick < 25) begin
        add_access(OP_READ, a, w, 8'($urandom));
      end else if (pick < 80) begin
        add_access(OP_WRITE, BASE_ADDR + 16'($urandom_range(1, 13)), w, 8'($urandom));
      end else if (pick < 90) begin
        add_access(OP_WRITE, BASE_ADDR, w | 8'h01, 8'($urandom));
      end else begin
        if (a == BASE_ADDR) w[0] = 1'b1;
        add_access(OP_WRITE, a, w, 8'($urandom));
      end
    end

    // Final program: slot addresses often repeat an earlier slot
    for (k = 0; k < NUM_SLOTS; k++) begin
      if (k > 0 && $urandom_range(0, 2) != 0)
        aim_addr[k] = aim_addr[$urandom_range(0, k - 1)];
      else
        aim_addr[k] = {1'b1, 15'($urandom)};
      aim_cmp[k] = 8'($urandom);
      add_access(OP_WRITE, BASE_ADDR + 16'(BYTES_PER_SLOT*k + 1),
                 {1'($urandom_range(0, 1)), aim_addr[k][14:8]}, 8'($urandom));
      add_access(OP_WRITE, BASE_ADDR + 16'(BYTES_PER_SLOT*k + 2), aim_addr[k][7:0],
                 8'($urandom));
      add_access(OP_WRITE, BASE_ADDR + 16'(BYTES_PER_SLOT*k + 3), aim_cmp[k], 8'($urandom));
      add_access(OP_WRITE, BASE_ADDR + 16'(BYTES_PER_SLOT*k + 4), 8'($urandom),
                 8'($urandom));
    end
    ctrl_val = 8'($urandom) | 8'h01;
    add_access(OP_WRITE, BASE_ADDR, ctrl_val, 8'($urandom));
    // enter patch mode
    add_access(OP_WRITE, BASE_ADDR, 8'($urandom) & 8'hFE, 8'($urandom));

    // Directed patch-mode reads at each slot, compare hit and miss
    for (k = 0; k < NUM_SLOTS; k++) begin
      add_access(OP_READ, aim_addr[k], 8'h00, aim_cmp[k]);
      add_access(OP_READ, aim_addr[k], 8'hFF, ~aim_cmp[k]);
    end
    add_access(OP_WRITE, BASE_ADDR, 8'h01, 8'h00);
    add_access(OP_WRITE, BASE_ADDR + 16'd1, 8'hFF, 8'h00);
    add_access(OP_READ, aim_addr[0], 8'h00, aim_cmp[0]);
    add_access(OP_READ, {1'b0, aim_addr[0][14:0]}, 8'h00, aim_cmp[0]);

    // Random patch-mode traffic aimed mostly at slot addresses
    for (int i = 0; i < 1500; i++) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, NUM_SLOTS - 1);
      w = 8'($urandom);
      if (pick < 60) begin
        add_access(OP_READ, aim_addr[k], w,
                   $urandom_range(0, 1) ? aim_cmp[$urandom_range(0, NUM_SLOTS - 1)]
                                        : 8'($urandom));
      end else if (pick < 75) begin
        add_access(OP_READ, rand_addr(), w, 8'($urandom));
      end else if (pick < 90) begin
        a = ($urandom_range(0, 2) == 0) ? BASE_ADDR : rand_addr();
        add_access(OP_WRITE, a, w, 8'($urandom));
      end else begin
        a = aim_addr[k] ^ (16'h1 << $urandom_range(0, 15));
        add_access(OP_READ, a, w, aim_cmp[k]);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (access_q.size() != 0 || have_item || s_tvalid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_cheat_code_read_patcher: clean");
    end else begin
      $display("tb_cheat_code_read_patcher: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ccrp_pkg.sv
hdl/ccrp_setup.sv
hdl/ccrp_match.sv
hdl/cheat_code_read_patcher.sv
verif/tb_cheat_code_read_patcher.sv
